// ===== sv/bbe_pkg.sv =====
// Shared types and constants for the B-spline basis evaluator.
package bbe_pkg;

    localparam int FRAC_BITS  = 30;
    localparam int VAL_W      = 31;
    localparam int IDX_W      = 6;
    localparam int DEG_W      = 3;
    localparam int KNOT_DEPTH = 64;
    localparam int DIFF_W     = 32;
    localparam int DEN_W      = 33;

    localparam logic [VAL_W-1:0] Q_ONE   = VAL_W'(1) << FRAC_BITS;
    localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    localparam logic REG_DEGREE = 1'b0;
    localparam logic REG_COUNT  = 1'b1;

    typedef struct packed {
        logic                    start;
        logic [VAL_W-1:0]        basis;
        logic signed [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                     busy;
        logic                     done;
        logic signed [DIFF_W-1:0] quot;
    } div_rsp_t;

endpackage

// ===== sv/bbe_divider.sv =====
// Radix-2 restoring divider giving (basis << 30) / den, truncated and saturated to 32 bits.
module bbe_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  bbe_pkg::div_req_t req,
    output bbe_pkg::div_rsp_t rsp
);
    import bbe_pkg::*;

    logic [DEN_W-1:0]  mag;
    logic [DEN_W-1:0]  hi;
    logic [DEN_W:0]    trial;
    logic              ge;
    logic [31:0]       q_new;
    logic [DEN_W-1:0]  rem_reg;
    logic [31:0]       lo_reg;
    logic [31:0]       q_reg;
    logic [DEN_W-1:0]  mag_reg;
    logic              neg_reg;
    logic [4:0]        cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic signed [31:0] quot_reg;

    assign mag   = req.den[DEN_W-1] ? DEN_W'(-req.den) : DEN_W'(req.den);
    assign hi    = DEN_W'(req.basis[VAL_W-1:2]);
    assign trial = {rem_reg, lo_reg[31]};
    assign ge    = trial >= {1'b0, mag_reg};
    assign q_new = {q_reg[30:0], ge};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else begin
            done_reg <= 1'b0;
            if (req.start) begin
                neg_reg <= req.den[DEN_W-1];
                mag_reg <= mag;
                if (hi >= mag) begin
                    quot_reg <= req.den[DEN_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                    done_reg <= 1'b1;
                end
                else begin
                    rem_reg  <= hi;
                    lo_reg   <= {req.basis[1:0], 30'b0};
                    q_reg    <= '0;
                    cnt_reg  <= '0;
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg) begin
                rem_reg <= ge ? DEN_W'(trial - {1'b0, mag_reg}) : trial[DEN_W-1:0];
                lo_reg  <= {lo_reg[30:0], 1'b0};
                q_reg   <= q_new;
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    if (neg_reg) begin
                        quot_reg <= (q_new > 32'h8000_0000) ? 32'sh8000_0000 : -$signed(q_new);
                    end
                    else begin
                        quot_reg <= q_new[31] ? 32'sh7FFF_FFFF : $signed(q_new);
                    end
                end
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

// ===== sv/bspline_basis_evaluator.sv =====
// Top level of the B-spline basis evaluator: knot store, sequencer and shared multiplier.
//
//  channel   direction  handshake          contents
//  s_*       in         tvalid/tready      tuser opcode; tdata knot index, knot, parameter
//  m_*       out        tvalid/tready      tdata span, column, basis; tuser error; tlast
//  cfg_*     in         cfg_we             register index and write data
//
// A load item is written into the knot store as it is accepted. An evaluate item runs the
// knot search (SRCH, SRCHW per step), then the p(p+1)/2 recurrence steps, each waiting on
// the 32-step shared divider, then one EMIT handshake per result item.
// Reset is asynchronous and leaves the block idle; the knot store is not cleared.
// The block is not ready while an item is at work; a stalled result item holds the block.
module bspline_basis_evaluator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // knot_index[5:0], knot_value[36:6], param_value[67:37]
    input  logic        s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // span_index[5:0], column_index[11:6], basis_value[42:12]
    output logic        m_tuser,   // div_error
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [5:0]  cfg_data
);
    import bbe_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SRCH  = 4'd1;
    localparam logic [3:0] ST_SRCHW = 4'd2;
    localparam logic [3:0] ST_INIT  = 4'd3;
    localparam logic [3:0] ST_LDL   = 4'd4;
    localparam logic [3:0] ST_LDLW  = 4'd5;
    localparam logic [3:0] ST_LDRW  = 4'd6;
    localparam logic [3:0] ST_DIVS  = 4'd7;
    localparam logic [3:0] ST_DIVW  = 4'd8;
    localparam logic [3:0] ST_MUL1  = 4'd9;
    localparam logic [3:0] ST_ACC1  = 4'd10;
    localparam logic [3:0] ST_MUL2  = 4'd11;
    localparam logic [3:0] ST_ACC2  = 4'd12;
    localparam logic [3:0] ST_EMIT  = 4'd13;

    logic [3:0]               state_reg;
    logic [DEG_W-1:0]         degree_reg;
    logic [IDX_W-1:0]         count_reg;
    logic [VAL_W-1:0]         knot_mem [KNOT_DEPTH];
    logic [VAL_W-1:0]         rdata_reg;
    logic [IDX_W-1:0]         rd_addr;
    logic [VAL_W-1:0]         u_reg;
    logic [IDX_W-1:0]         span_reg;
    logic [3:0]               j_reg;
    logic [DEG_W-1:0]         r_reg;
    logic                     err_reg;
    logic [VAL_W-1:0]         basis_reg [8];
    logic signed [DIFF_W-1:0] left_reg  [8];
    logic signed [DIFF_W-1:0] right_reg [8];
    logic signed [DIFF_W-1:0] temp_reg;
    logic signed [63:0]       prod_reg;
    logic signed [33:0]       saved_reg;
    logic                     out_valid_reg;
    logic [47:0]              out_data_reg;
    logic                     out_err_reg;
    logic                     out_last_reg;

    logic [IDX_W:0]           addr_lo;
    logic [IDX_W:0]           addr_hi;
    logic [DEG_W-1:0]         jr;
    logic [DEG_W-1:0]         r1;
    logic signed [DEN_W-1:0]  den;
    logic signed [DIFF_W-1:0] mul_a;
    logic signed [33:0]       prod_sh;
    logic signed [34:0]       acc;
    logic [IDX_W-1:0]         column;
    div_req_t                 dreq;
    div_rsp_t                 drsp;

    function automatic logic [VAL_W-1:0] sat_basis(input logic signed [34:0] x);
        if (x < 0) begin
            return '0;
        end
        else if (x > 35'sd2147483647) begin
            return VAL_MAX;
        end
        return x[VAL_W-1:0];
    endfunction

    assign addr_lo = {1'b0, span_reg} + 7'd1 - {3'b0, j_reg};
    assign addr_hi = {1'b0, span_reg} + {3'b0, j_reg};
    assign jr      = DEG_W'(j_reg - {1'b0, r_reg});
    assign r1      = r_reg + 3'd1;
    assign den     = DEN_W'(right_reg[r1]) + DEN_W'(left_reg[jr]);
    assign mul_a   = (state_reg == ST_MUL1) ? right_reg[r1] : left_reg[jr];
    assign prod_sh = 34'(prod_reg >>> FRAC_BITS);
    assign acc     = 35'(saved_reg) + 35'(prod_sh);
    assign column  = span_reg - IDX_W'(degree_reg) + IDX_W'(r_reg);

    always_comb begin
        unique case (state_reg)
            ST_LDL:  rd_addr = addr_lo[IDX_W-1:0];
            ST_LDLW: rd_addr = addr_hi[IDX_W] ? {IDX_W{1'b1}} : addr_hi[IDX_W-1:0];
            default: rd_addr = span_reg;
        endcase
    end

    assign dreq.start = (state_reg == ST_DIVS) && (den != 0);
    assign dreq.basis = basis_reg[r_reg];
    assign dreq.den   = den;

    bbe_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    always_ff @(posedge clk) begin
        if (s_tvalid && s_tready && s_tuser == OP_LOAD) begin
            knot_mem[s_tdata[5:0]] <= s_tdata[36:6];
        end
        rdata_reg <= knot_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            degree_reg <= 3'd3;
            count_reg  <= 6'd4;
        end
        else if (cfg_we) begin
            if (cfg_index == REG_DEGREE) begin
                degree_reg <= cfg_data[DEG_W-1:0];
            end
            else begin
                count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk) begin
        prod_reg <= mul_a * temp_reg;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid && s_tuser == OP_EVAL) begin
                        u_reg     <= s_tdata[67:37];
                        span_reg  <= IDX_W'(degree_reg) + 6'd1;
                        state_reg <= ST_SRCH;
                    end
                end
                ST_SRCH: begin
                    if (span_reg < count_reg) begin
                        state_reg <= ST_SRCHW;
                    end
                    else begin
                        span_reg  <= span_reg - 6'd1;
                        state_reg <= ST_INIT;
                    end
                end
                ST_SRCHW: begin
                    if (rdata_reg <= u_reg) begin
                        span_reg  <= span_reg + 6'd1;
                        state_reg <= ST_SRCH;
                    end
                    else begin
                        span_reg  <= span_reg - 6'd1;
                        state_reg <= ST_INIT;
                    end
                end
                ST_INIT: begin
                    for (int i = 0; i < 8; i++) begin
                        basis_reg[i] <= Q_ONE;
                        left_reg[i]  <= '0;
                        right_reg[i] <= '0;
                    end
                    err_reg   <= 1'b0;
                    j_reg     <= 4'd1;
                    r_reg     <= '0;
                    state_reg <= (degree_reg == '0) ? ST_EMIT : ST_LDL;
                end
                ST_LDL: begin
                    state_reg <= ST_LDLW;
                end
                ST_LDLW: begin
                    left_reg[j_reg[2:0]] <= $signed({1'b0, u_reg} - {1'b0, rdata_reg});
                    state_reg <= ST_LDRW;
                end
                ST_LDRW: begin
                    right_reg[j_reg[2:0]] <= $signed({1'b0, rdata_reg} - {1'b0, u_reg});
                    r_reg     <= '0;
                    saved_reg <= '0;
                    state_reg <= ST_DIVS;
                end
                ST_DIVS: begin
                    if (den == 0) begin
                        temp_reg  <= '0;
                        err_reg   <= 1'b1;
                        state_reg <= ST_MUL1;
                    end
                    else begin
                        state_reg <= ST_DIVW;
                    end
                end
                ST_DIVW: begin
                    if (drsp.done) begin
                        temp_reg  <= drsp.quot;
                        state_reg <= ST_MUL1;
                    end
                end
                ST_MUL1: begin
                    state_reg <= ST_ACC1;
                end
                ST_ACC1: begin
                    basis_reg[r_reg] <= sat_basis(acc);
                    state_reg        <= ST_MUL2;
                end
                ST_MUL2: begin
                    state_reg <= ST_ACC2;
                end
                ST_ACC2: begin
                    saved_reg <= prod_sh;
                    if (r1 == j_reg[2:0]) begin
                        basis_reg[j_reg[2:0]] <= sat_basis(35'(prod_sh));
                        r_reg <= '0;
                        if (j_reg == {1'b0, degree_reg}) begin
                            state_reg <= ST_EMIT;
                        end
                        else begin
                            j_reg     <= j_reg + 4'd1;
                            state_reg <= ST_LDL;
                        end
                    end
                    else begin
                        r_reg     <= r1;
                        state_reg <= ST_DIVS;
                    end
                end
                ST_EMIT: begin
                    if (!out_valid_reg) begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {5'b0, basis_reg[r_reg], column, span_reg};
                        out_err_reg   <= err_reg;
                        out_last_reg  <= (r_reg == degree_reg);
                    end
                    else if (m_tready) begin
                        out_valid_reg <= 1'b0;
                        if (out_last_reg) begin
                            state_reg <= ST_IDLE;
                        end
                        else begin
                            r_reg <= r1;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_err_reg;
    assign m_tlast  = out_last_reg;

    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while a result item is pending");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> s_tready)
        else $error("block not idle after the last result item");

    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        dreq.start |-> !drsp.busy)
        else $error("divider started while busy");

endmodule
